// File: rtl/als_pkg.sv
package als_pkg;

  localparam int unsigned POS_W      = 10;
  localparam int unsigned WIN_W      = 6;
  localparam int unsigned RATE_W     = 12;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned US_W       = 16;
  localparam int unsigned SP_W       = 24;
  localparam int unsigned PROD_W     = US_W + RATE_W;
  localparam int unsigned STEP_W     = 17;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // floor(us * rate * 256 / 1e6) = floor(prod * 4 / 15625), done as a multiply by a
  // rounded-up reciprocal of 2^44 / 15625 and a shift; exact for prod below 2^28.
  localparam int unsigned RECIP_W     = 31;
  localparam int unsigned RECIP_SHIFT = 42;
  localparam logic [RECIP_W-1:0] RECIP_M = 31'd1125899907;

  localparam logic [POS_W-1:0] LONG_END  = 10'd250;
  localparam logic [POS_W-1:0] SHORT_END = 10'd225;

  typedef enum logic [2:0] {
    MODE_INIT     = 3'd0,
    MODE_HOME     = 3'd1,
    MODE_ARMING   = 3'd2,
    MODE_READY    = 3'd3,
    MODE_FIRING   = 3'd4,
    MODE_TWOSTAGE = 3'd5,
    MODE_PASSING  = 3'd6,
    MODE_RETRACT  = 3'd7
  } als_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOME_POS     = 3'd0,
    CFG_READY_POS    = 3'd1,
    CFG_FIRE_POS     = 3'd2,
    CFG_READY_WIN    = 3'd3,
    CFG_HOME_MARGIN  = 3'd4,
    CFG_RETRACT_RATE = 3'd5,
    CFG_SHOOT_RATE   = 3'd6,
    CFG_LOAD_RATE    = 3'd7
  } als_cfg_idx_e;

  localparam logic [CMD_W-1:0] DRIVE_NONE   = 2'd0;
  localparam logic [CMD_W-1:0] DRIVE_STOP   = 2'd1;
  localparam logic [CMD_W-1:0] DRIVE_DOWN   = 2'd2;
  localparam logic [CMD_W-1:0] OVR_KEEP     = 2'd0;
  localparam logic [CMD_W-1:0] OVR_ENABLE   = 2'd1;
  localparam logic [CMD_W-1:0] OVR_DISABLE  = 2'd2;
  localparam logic [CMD_W-1:0] COMP_KEEP    = 2'd0;
  localparam logic [CMD_W-1:0] COMP_OFF     = 2'd1;
  localparam logic [CMD_W-1:0] COMP_ON      = 2'd2;
  localparam logic [CMD_W-1:0] GRAB_KEEP    = 2'd0;
  localparam logic [CMD_W-1:0] GRAB_EXTEND  = 2'd1;
  localparam logic [CMD_W-1:0] GRAB_RETRACT = 2'd2;
  localparam logic [CMD_W-1:0] ROLL_STOP    = 2'd0;
  localparam logic [CMD_W-1:0] ROLL_IN      = 2'd1;
  localparam logic [CMD_W-1:0] ROLL_OUT     = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] home_pos;
    logic [POS_W-1:0] ready_pos;
    logic [POS_W-1:0] fire_pos;
    logic [WIN_W-1:0] ready_win;
    logic [WIN_W-1:0] home_margin;
  } als_cfg_t;

  typedef struct packed {
    logic ready_held;
    logic arm_held;
    logic pass_held;
    logic intake_held;
    logic shot_pressed;
    logic long_shot_pressed;
    logic short_shot_pressed;
    logic upper_limit_hit;
    logic lower_limit_hit;
    logic grabber_extended;
  } als_btn_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] count;
    logic [STEP_W-1:0]         step_retract;
    logic [STEP_W-1:0]         step_shoot;
    logic [STEP_W-1:0]         step_load;
    als_btn_t                  btn;
  } als_tick_t;

  typedef struct packed {
    logic [CMD_W-1:0] arm_drive;
    logic [CMD_W-1:0] override_cmd;
    logic             encoder_reset;
    logic [CMD_W-1:0] compressor_cmd;
    logic [CMD_W-1:0] grabber_cmd;
    logic [CMD_W-1:0] roller_cmd;
  } als_cmd_t;

  function automatic logic [STEP_W-1:0] ramp_step(input logic [PROD_W-1:0] prod);
    logic [PROD_W+RECIP_W-1:0] full;
    full = {{RECIP_W{1'b0}}, prod} * {{PROD_W{1'b0}}, RECIP_M};
    return full[RECIP_SHIFT +: STEP_W];
  endfunction

endpackage

// File: rtl/als_mode_fsm.sv
module als_mode_fsm import als_pkg::*; (
  input  als_mode_e               mode_i,
  input  logic signed [SP_W-1:0]  setpoint_i,
  input  logic [POS_W-1:0]        stage_end_i,
  input  logic                    loop_i,
  input  als_cfg_t                cfg_i,
  input  als_tick_t               tick_i,
  output als_mode_e               mode_o,
  output logic signed [SP_W-1:0]  setpoint_o,
  output logic [POS_W-1:0]        stage_end_o,
  output logic                    loop_o,
  output als_cmd_t                cmd_o
);

  logic signed [17:0] cnt_x;
  logic signed [17:0] win_lo;
  logic signed [17:0] win_hi;
  logic signed [17:0] home_lim;
  logic signed [17:0] fire_x;
  logic signed [17:0] end_x;
  logic               in_window;
  logic               near_home;
  logic               fire_done;
  logic               stage_done;

  logic signed [25:0] sp_x;
  logic signed [25:0] home_sp;
  logic [POS_W-1:0]   up_target;
  logic [STEP_W-1:0]  up_step;
  logic signed [25:0] up_lim;
  logic signed [25:0] up_sum;
  logic signed [25:0] up_sp;
  logic signed [25:0] ret_base;
  logic signed [25:0] ret_diff;
  logic signed [25:0] ret_sp;

  assign cnt_x    = {{2{tick_i.count[COUNT_W-1]}}, tick_i.count};
  assign win_lo   = $signed({8'd0, cfg_i.ready_pos}) - $signed({12'd0, cfg_i.ready_win});
  assign win_hi   = $signed({8'd0, cfg_i.ready_pos}) + $signed({12'd0, cfg_i.ready_win});
  assign home_lim = $signed({8'd0, cfg_i.home_pos}) + $signed({12'd0, cfg_i.home_margin});
  assign fire_x   = $signed({8'd0, cfg_i.fire_pos});
  assign end_x    = $signed({8'd0, stage_end_i});

  assign in_window  = (cnt_x > win_lo) && (cnt_x < win_hi);
  assign near_home  = (cnt_x <= home_lim);
  assign fire_done  = tick_i.btn.upper_limit_hit || (cnt_x >= fire_x);
  assign stage_done = tick_i.btn.upper_limit_hit || (cnt_x >= end_x);

  // Positions in 1/256 counts, carried two bits wider than the setpoint so that
  // the ramp sums cannot wrap; every clamped result fits back into 24 bits.
  assign sp_x    = {{2{setpoint_i[SP_W-1]}}, setpoint_i};
  assign home_sp = $signed({8'd0, cfg_i.home_pos, 8'd0});

  assign up_target = (mode_i == MODE_READY)  ? cfg_i.ready_pos :
                     (mode_i == MODE_FIRING) ? cfg_i.fire_pos  : stage_end_i;
  assign up_step   = (mode_i == MODE_READY) ? tick_i.step_load : tick_i.step_shoot;
  assign up_lim    = $signed({8'd0, up_target, 8'd0});
  assign up_sum    = sp_x + $signed({9'd0, up_step});
  assign up_sp     = (up_sum >= up_lim) ? up_lim : up_sum;

  assign ret_base = near_home ? home_sp : sp_x;
  assign ret_diff = ret_base - $signed({9'd0, tick_i.step_retract});
  assign ret_sp   = (ret_diff <= home_sp) ? home_sp : ret_diff;

  always_comb begin : next_mode
    mode_o = mode_i;
    unique case (mode_i)
      MODE_INIT: begin
        if (tick_i.btn.lower_limit_hit) begin
          mode_o = MODE_HOME;
        end
      end
      MODE_HOME: begin
        // Later requests win: ready, then arm, then pass.
        if (tick_i.btn.pass_held) begin
          mode_o = MODE_PASSING;
        end else if (tick_i.btn.arm_held) begin
          mode_o = MODE_ARMING;
        end else if (tick_i.btn.ready_held) begin
          mode_o = MODE_READY;
        end
      end
      MODE_ARMING: begin
        if (!tick_i.btn.arm_held) begin
          mode_o = MODE_HOME;
        end
      end
      MODE_READY: begin
        if (!tick_i.btn.ready_held) begin
          mode_o = MODE_RETRACT;
        end else if (in_window && tick_i.btn.grabber_extended) begin
          if (tick_i.btn.long_shot_pressed || tick_i.btn.short_shot_pressed) begin
            mode_o = MODE_TWOSTAGE;
          end else if (tick_i.btn.shot_pressed) begin
            mode_o = MODE_FIRING;
          end
        end
      end
      MODE_FIRING: begin
        if (fire_done) begin
          mode_o = MODE_RETRACT;
        end
      end
      MODE_TWOSTAGE: begin
        if (stage_done) begin
          mode_o = MODE_RETRACT;
        end
      end
      MODE_PASSING: begin
        if (!tick_i.btn.pass_held) begin
          mode_o = MODE_HOME;
        end
      end
      MODE_RETRACT: begin
        if (near_home) begin
          mode_o = MODE_HOME;
        end
      end
    endcase
  end

  always_comb begin : outputs
    cmd_o       = '0;
    setpoint_o  = setpoint_i;
    stage_end_o = stage_end_i;
    loop_o      = loop_i;

    // Grabber and rollers follow the mode held before this item.
    unique case (mode_i)
      MODE_INIT: begin
        cmd_o.grabber_cmd = GRAB_EXTEND;
      end
      MODE_HOME: begin
        cmd_o.grabber_cmd = GRAB_RETRACT;
        cmd_o.roller_cmd  = tick_i.btn.intake_held ? ROLL_IN : ROLL_STOP;
      end
      MODE_ARMING: begin
        cmd_o.grabber_cmd = GRAB_EXTEND;
        cmd_o.roller_cmd  = (tick_i.btn.grabber_extended && tick_i.btn.intake_held) ?
                            ROLL_IN : ROLL_STOP;
      end
      MODE_READY, MODE_FIRING, MODE_RETRACT: begin
        cmd_o.grabber_cmd = GRAB_EXTEND;
        cmd_o.roller_cmd  = tick_i.btn.grabber_extended ? ROLL_STOP : ROLL_IN;
      end
      MODE_PASSING: begin
        cmd_o.grabber_cmd = GRAB_RETRACT;
        cmd_o.roller_cmd  = tick_i.btn.grabber_extended ? ROLL_STOP : ROLL_OUT;
      end
      MODE_TWOSTAGE: begin
        cmd_o.grabber_cmd = GRAB_KEEP;
        cmd_o.roller_cmd  = ROLL_STOP;
      end
    endcase

    unique case (mode_i)
      MODE_INIT: begin
        if (tick_i.btn.lower_limit_hit) begin
          cmd_o.arm_drive     = DRIVE_STOP;
          cmd_o.encoder_reset = 1'b1;
          loop_o              = 1'b1;
          setpoint_o          = home_sp[SP_W-1:0];
        end else if (tick_i.btn.grabber_extended) begin
          cmd_o.arm_drive = DRIVE_DOWN;
        end
      end
      MODE_HOME: begin
        if (tick_i.btn.ready_held) begin
          cmd_o.compressor_cmd = COMP_OFF;
        end
      end
      MODE_ARMING: begin
        if (tick_i.btn.lower_limit_hit) begin
          cmd_o.arm_drive     = DRIVE_STOP;
          cmd_o.encoder_reset = 1'b1;
          loop_o              = 1'b1;
          setpoint_o          = '0;
        end else begin
          cmd_o.arm_drive = DRIVE_DOWN;
        end
        if (!tick_i.btn.arm_held) begin
          cmd_o.arm_drive = DRIVE_STOP;
          loop_o          = 1'b1;
          setpoint_o      = home_sp[SP_W-1:0];
        end
      end
      MODE_READY: begin
        if (!tick_i.btn.ready_held) begin
          setpoint_o = {tick_i.count, 8'd0};
        end else if (in_window) begin
          if (tick_i.btn.grabber_extended) begin
            if (tick_i.btn.shot_pressed || tick_i.btn.long_shot_pressed ||
                tick_i.btn.short_shot_pressed) begin
              cmd_o.override_cmd = OVR_ENABLE;
            end
            if (tick_i.btn.short_shot_pressed) begin
              stage_end_o = SHORT_END;
            end else if (tick_i.btn.long_shot_pressed) begin
              stage_end_o = LONG_END;
            end
          end
        end else if (tick_i.btn.grabber_extended) begin
          setpoint_o = up_sp[SP_W-1:0];
        end
      end
      MODE_FIRING: begin
        if (fire_done) begin
          setpoint_o         = {6'd0, cfg_i.fire_pos, 8'd0};
          cmd_o.override_cmd = OVR_DISABLE;
        end else begin
          setpoint_o = up_sp[SP_W-1:0];
        end
      end
      MODE_TWOSTAGE: begin
        if (stage_done) begin
          setpoint_o         = {6'd0, stage_end_i, 8'd0};
          cmd_o.override_cmd = OVR_DISABLE;
        end else begin
          setpoint_o = up_sp[SP_W-1:0];
        end
      end
      MODE_PASSING: begin
        setpoint_o = setpoint_i;
      end
      MODE_RETRACT: begin
        if (near_home) begin
          cmd_o.compressor_cmd = COMP_ON;
        end
        setpoint_o = ret_sp[SP_W-1:0];
      end
    endcase
  end

endmodule

// File: rtl/arm_launch_sequencer_unit.sv
// Arm launch sequencer. Each item is one control tick; it yields exactly one
// result carrying the new setpoint (signed, 1/256 counts), the mode after the tick
// and the drive, override, encoder-reset, compressor, grabber and roller commands.
// The block is a three-stage pipeline and takes one item every cycle unless a
// stalled result has backed it up. The first stage forms elapsed_us times each
// of the three ramp rates, the second turns those products into ramp steps with
// a reciprocal multiplier, and the result stage runs the mode logic and updates
// the mode, setpoint, two-stage end and loop-enable registers, which drive the
// result ports directly. Ready falls only when the result is held and both
// earlier stages are full. Configuration writes must be made while no item is
// in flight.
module arm_launch_sequencer_unit import als_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COUNT_W-1:0]    encoder_count_i,
  input  logic [US_W-1:0]              elapsed_us_i,
  input  logic                         ready_held_i,
  input  logic                         arm_held_i,
  input  logic                         pass_held_i,
  input  logic                         intake_held_i,
  input  logic                         shot_pressed_i,
  input  logic                         long_shot_pressed_i,
  input  logic                         short_shot_pressed_i,
  input  logic                         upper_limit_hit_i,
  input  logic                         lower_limit_hit_i,
  input  logic                         grabber_extended_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SP_W-1:0]       setpoint_out_o,
  output logic                         controller_on_o,
  output logic [CMD_W-1:0]             arm_drive_o,
  output logic [CMD_W-1:0]             override_cmd_o,
  output logic                         encoder_reset_o,
  output logic [CMD_W-1:0]             compressor_cmd_o,
  output logic [CMD_W-1:0]             grabber_cmd_o,
  output logic [CMD_W-1:0]             roller_cmd_o,
  output logic [2:0]                   mode_out_o
);

  als_cfg_t            cfg_q;
  logic [RATE_W-1:0]   retract_rate_q;
  logic [RATE_W-1:0]   shoot_rate_q;
  logic [RATE_W-1:0]   load_rate_q;

  logic                      s1_valid_q;
  logic signed [COUNT_W-1:0] s1_count_q;
  als_btn_t                  s1_btn_q;
  logic [PROD_W-1:0]         s1_prod_retract_q;
  logic [PROD_W-1:0]         s1_prod_shoot_q;
  logic [PROD_W-1:0]         s1_prod_load_q;

  logic      s2_valid_q;
  als_tick_t s2_tick_q;

  logic                   out_valid_q;
  als_cmd_t               cmd_q;
  als_mode_e              mode_q;
  als_mode_e              mode_d;
  logic signed [SP_W-1:0] setpoint_q;
  logic signed [SP_W-1:0] setpoint_d;
  logic [POS_W-1:0]       stage_end_q;
  logic [POS_W-1:0]       stage_end_d;
  logic                   loop_q;
  logic                   loop_d;
  als_cmd_t               cmd_d;

  logic adv_out;
  logic adv_s2;
  logic adv_s1;
  logic load_out;

  assign adv_out    = !out_valid_q || out_ready_i;
  assign adv_s2     = !s2_valid_q || adv_out;
  assign adv_s1     = !s1_valid_q || adv_s2;
  assign in_ready_o = adv_s1;
  assign load_out   = s2_valid_q && adv_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.home_pos    <= 10'd5;
      cfg_q.ready_pos   <= 10'd30;
      cfg_q.fire_pos    <= 10'd225;
      cfg_q.ready_win   <= 6'd6;
      cfg_q.home_margin <= 6'd5;
      retract_rate_q    <= 12'd250;
      shoot_rate_q      <= 12'd900;
      load_rate_q       <= 12'd100;
    end else if (cfg_we_i) begin
      unique case (als_cfg_idx_e'(cfg_idx_i))
        CFG_HOME_POS:     cfg_q.home_pos    <= cfg_data_i[POS_W-1:0];
        CFG_READY_POS:    cfg_q.ready_pos   <= cfg_data_i[POS_W-1:0];
        CFG_FIRE_POS:     cfg_q.fire_pos    <= cfg_data_i[POS_W-1:0];
        CFG_READY_WIN:    cfg_q.ready_win   <= cfg_data_i[WIN_W-1:0];
        CFG_HOME_MARGIN:  cfg_q.home_margin <= cfg_data_i[WIN_W-1:0];
        CFG_RETRACT_RATE: retract_rate_q    <= cfg_data_i[RATE_W-1:0];
        CFG_SHOOT_RATE:   shoot_rate_q      <= cfg_data_i[RATE_W-1:0];
        CFG_LOAD_RATE:    load_rate_q       <= cfg_data_i[RATE_W-1:0];
      endcase
    end
  end

  // Pipeline occupancy and the sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_INIT;
      setpoint_q  <= '0;
      stage_end_q <= '0;
      loop_q      <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv_s2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (adv_out) begin
        out_valid_q <= s2_valid_q;
      end
      if (load_out) begin
        mode_q      <= mode_d;
        setpoint_q  <= setpoint_d;
        stage_end_q <= stage_end_d;
        loop_q      <= loop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && adv_s1) begin
      s1_count_q                  <= encoder_count_i;
      s1_btn_q.ready_held         <= ready_held_i;
      s1_btn_q.arm_held           <= arm_held_i;
      s1_btn_q.pass_held          <= pass_held_i;
      s1_btn_q.intake_held        <= intake_held_i;
      s1_btn_q.shot_pressed       <= shot_pressed_i;
      s1_btn_q.long_shot_pressed  <= long_shot_pressed_i;
      s1_btn_q.short_shot_pressed <= short_shot_pressed_i;
      s1_btn_q.upper_limit_hit    <= upper_limit_hit_i;
      s1_btn_q.lower_limit_hit    <= lower_limit_hit_i;
      s1_btn_q.grabber_extended   <= grabber_extended_i;
      s1_prod_retract_q <= {{RATE_W{1'b0}}, elapsed_us_i} * {{US_W{1'b0}}, retract_rate_q};
      s1_prod_shoot_q   <= {{RATE_W{1'b0}}, elapsed_us_i} * {{US_W{1'b0}}, shoot_rate_q};
      s1_prod_load_q    <= {{RATE_W{1'b0}}, elapsed_us_i} * {{US_W{1'b0}}, load_rate_q};
    end
    if (s1_valid_q && adv_s2) begin
      s2_tick_q.count        <= s1_count_q;
      s2_tick_q.btn          <= s1_btn_q;
      s2_tick_q.step_retract <= ramp_step(s1_prod_retract_q);
      s2_tick_q.step_shoot   <= ramp_step(s1_prod_shoot_q);
      s2_tick_q.step_load    <= ramp_step(s1_prod_load_q);
    end
    if (load_out) begin
      cmd_q <= cmd_d;
    end
  end

  als_mode_fsm u_fsm (
    .mode_i      (mode_q),
    .setpoint_i  (setpoint_q),
    .stage_end_i (stage_end_q),
    .loop_i      (loop_q),
    .cfg_i       (cfg_q),
    .tick_i      (s2_tick_q),
    .mode_o      (mode_d),
    .setpoint_o  (setpoint_d),
    .stage_end_o (stage_end_d),
    .loop_o      (loop_d),
    .cmd_o       (cmd_d)
  );

  assign out_valid_o      = out_valid_q;
  assign setpoint_out_o   = setpoint_q;
  assign controller_on_o  = loop_q;
  assign mode_out_o       = mode_q;
  assign arm_drive_o      = cmd_q.arm_drive;
  assign override_cmd_o   = cmd_q.override_cmd;
  assign encoder_reset_o  = cmd_q.encoder_reset;
  assign compressor_cmd_o = cmd_q.compressor_cmd;
  assign grabber_cmd_o    = cmd_q.grabber_cmd;
  assign roller_cmd_o     = cmd_q.roller_cmd;

  // Once the position loop is on, only reset turns it off.
  a_loop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loop_q |=> loop_q)
    else $error("position loop dropped without reset");

  a_encrst_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && encoder_reset_o) |-> (arm_drive_o == DRIVE_STOP))
    else $error("encoder reset without arm stop");

  a_stage_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_TWOSTAGE) |-> (stage_end_q == LONG_END || stage_end_q == SHORT_END))
    else $error("two-stage shot with unknown end position");

  // The state doubles as the result payload, so it must hold while a result waits.
  a_state_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(mode_q) && $stable(setpoint_q)))
    else $error("state changed under a stalled result");

endmodule
